>>> hdl/video_chip_cpu_register_port_macros.svh
// Assertion macros used by the register port module.
`ifndef VIDEO_CHIP_CPU_REGISTER_PORT_MACROS_SVH
`define VIDEO_CHIP_CPU_REGISTER_PORT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define VCP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define VCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/vcp_pkg.sv
package vcp_pkg;

    localparam int NAME_RAM_BYTES   = 2048;
    localparam int SPRITE_RAM_BYTES = 256;
    localparam int COLOR_ENTRIES    = 32;
    localparam int NAME_AW          = $clog2(NAME_RAM_BYTES);
    localparam int SPRITE_AW        = $clog2(SPRITE_RAM_BYTES);
    localparam int COLOR_AW         = $clog2(COLOR_ENTRIES);

    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_PEEK   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_VBL_ON = 3'd3,
        CMD_VBL_OFF = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CTRL   = 3'd0,
        REG_MASK   = 3'd1,
        REG_STATUS = 3'd2,
        REG_OAMADR = 3'd3,
        REG_OAMDAT = 3'd4,
        REG_SCROLL = 3'd5,
        REG_ADDR   = 3'd6,
        REG_DATA   = 3'd7
    } reg_t;

    typedef enum logic [1:0] {
        CHR_NONE  = 2'd0,
        CHR_READ  = 2'd1,
        CHR_WRITE = 2'd2
    } chr_t;

    typedef enum logic [1:0] {
        SP_PATTERN = 2'd0,
        SP_NAME    = 2'd1,
        SP_COLOR   = 2'd2
    } space_t;

    // Memory request issued by the register front end in stage 0.
    typedef struct packed {
        logic                 name_rd;
        logic                 name_wr;
        logic [NAME_AW-1:0]   name_addr;
        logic                 oam_wr;
        logic [SPRITE_AW-1:0] oam_addr;
        logic [7:0]           wdata;
    } mem_req_t;

    // Result staging information carried into stage 1.
    typedef struct packed {
        logic       use_oam;
        logic       use_name;
        logic       use_color;
        logic       to_buffer;
        logic       ret_new;
        logic [7:0] rd_direct;
        logic [7:0] color_val;
        chr_t       chr_access;
        logic [12:0] chr_address;
        logic [7:0] chr_write_data;
    } stage_t;

    function automatic logic [COLOR_AW-1:0] color_index(input logic [13:0] a);
        logic [4:0] i;
        i = a[4:0];
        if (i[4] && (i[1:0] == 2'b00))
            i[4] = 1'b0;
        return i[COLOR_AW-1:0];
    endfunction

    function automatic logic [NAME_AW-1:0] name_index(input logic [13:0] a,
                                                      input logic mirror);
        logic bank;
        bank = mirror ? a[11] : a[10];
        return NAME_AW'({bank, a[9:0]});
    endfunction

endpackage

>>> hdl/vcp_mem.sv
module vcp_mem (
    input  logic                         clk,
    input  vcp_pkg::mem_req_t            req,
    output logic [7:0]                   name_q,
    output logic [7:0]                   oam_q
);
    import vcp_pkg::*;

    logic [7:0] name_ram [NAME_RAM_BYTES];
    logic [7:0] oam_ram  [SPRITE_RAM_BYTES];

    // The nametable read data only changes on a read, so a stalled stage keeps its value.
    always_ff @(posedge clk)
    begin
        if (req.name_wr)
            name_ram[req.name_addr] <= req.wdata;
        if (req.name_rd)
            name_q <= name_ram[req.name_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.oam_wr)
            oam_ram[req.oam_addr] <= req.wdata;
        oam_q <= oam_ram[req.oam_addr];
    end

endmodule

>>> hdl/video_chip_cpu_register_port.sv
// A result passes through stage 1 and then the output register after its command is transferred.
// Throughput: one command per cycle; the input stalls only while the output is held off.
// A pending read-buffer update is forwarded to the next command, so reads never wait on it.
// Reset clears the control and valid registers except the vblank flag, which is kept,
// and clears the 32 palette bytes at once through their valid bits; stage data is not reset.
// Nametable and sprite RAM are not cleared and read undefined until written.
module video_chip_cpu_register_port (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  chr_read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [1:0]  chr_access,
    output logic [12:0] chr_address,
    output logic [7:0]  chr_write_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import vcp_pkg::*;
    `include "video_chip_cpu_register_port_macros.svh"

    logic        mirror_reg;
    logic [7:0]  ctrl_reg, mask_reg, status_reg, oamp_reg, buf_reg;
    logic        toggle_reg;
    logic [15:0] t_reg, v_reg;
    logic [2:0]  fx_reg;
    logic [7:0]  color_reg [COLOR_ENTRIES];
    logic [COLOR_ENTRIES-1:0] cvalid_reg;

    // Stage 1 (memory data returns) and output register.
    logic        s1_valid_reg;
    stage_t      s1_reg;
    logic        o_valid_reg;
    logic [7:0]  o_rd_reg;
    chr_t        o_acc_reg;
    logic [12:0] o_addr_reg;
    logic [7:0]  o_wd_reg;

    mem_req_t    req;
    stage_t      s0;
    logic [7:0]  name_q, oam_q;
    logic [7:0]  s1_val, s1_rd, buf_cur;
    logic        s1_load;
    logic        take, s1_adv;
    logic [13:0] va;
    space_t      sp;
    logic [COLOR_AW-1:0] cidx;
    logic [7:0]  cval;

    vcp_mem u_mem (.clk(clk), .req(req), .name_q(name_q), .oam_q(oam_q));

    // Stage 1 moves to the output register when that register is free or drains.
    assign s1_adv   = !o_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign take     = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Stage 1 value and the read buffer it produces, forwarded to stage 0.
    always_comb
    begin
        s1_val = s1_reg.use_name ? name_q : (s1_reg.use_oam ? oam_q : s1_reg.color_val);
        s1_load = s1_valid_reg && s1_reg.to_buffer;
        s1_rd = s1_reg.use_oam ? oam_q : s1_reg.rd_direct;
        if (s1_reg.to_buffer && s1_reg.ret_new)
            s1_rd = s1_val;
        buf_cur = s1_load ? s1_val : buf_reg;
    end

    assign va = v_reg[13:0];
    always_comb
    begin
        if (va < 14'h2000)
            sp = SP_PATTERN;
        else if (va < 14'h3F00)
            sp = SP_NAME;
        else
            sp = SP_COLOR;
        cidx = color_index(va);
        cval = cvalid_reg[cidx] ? color_reg[cidx] : 8'h00;
        cval = cval & (mask_reg[0] ? 8'h30 : 8'h3F);
    end

    always_comb
    begin
        req = '0;
        req.name_addr = name_index(va, mirror_reg);
        req.oam_addr  = oamp_reg;
        req.wdata     = write_data;
        s0 = '0;
        s0.color_val = cval;
        if (take && (command == CMD_READ))
        begin
            case (reg_index)
                REG_STATUS: s0.rd_direct = {status_reg[7:5], buf_cur[4:0]};
                REG_OAMDAT: s0.use_oam = 1'b1;
                REG_DATA:
                begin
                    s0.to_buffer = 1'b1;
                    s0.rd_direct = buf_cur;
                    s0.ret_new = (sp == SP_COLOR);
                    case (sp)
                        SP_PATTERN:
                        begin
                            s0.color_val = chr_read_data;
                            s0.chr_access = CHR_READ;
                            s0.chr_address = va[12:0];
                        end
                        SP_NAME:
                        begin
                            s0.use_name = 1'b1;
                            req.name_rd = 1'b1;
                        end
                        default: s0.use_color = 1'b1;
                    endcase
                end
                default: s0.rd_direct = 8'h00;
            endcase
        end
        else if (take && (command == CMD_PEEK))
        begin
            case (reg_index)
                REG_CTRL:   s0.rd_direct = ctrl_reg;
                REG_MASK:   s0.rd_direct = mask_reg;
                REG_STATUS: s0.rd_direct = status_reg;
                REG_OAMADR: s0.rd_direct = oamp_reg;
                REG_OAMDAT: s0.use_oam = 1'b1;
                default:    s0.rd_direct = 8'hFF;
            endcase
        end
        else if (take && (command == CMD_WRITE))
        begin
            if (reg_index == REG_OAMDAT)
                req.oam_wr = 1'b1;
            if (reg_index == REG_DATA)
            begin
                if (sp == SP_PATTERN)
                begin
                    s0.chr_access = CHR_WRITE;
                    s0.chr_address = va[12:0];
                    s0.chr_write_data = write_data;
                end
                else if (sp == SP_NAME)
                    req.name_wr = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
            ctrl_reg <= '0;
            mask_reg <= '0;
            status_reg <= {status_reg[7], 7'd0};
            oamp_reg <= '0;
            toggle_reg <= 1'b0;
            t_reg <= '0;
            v_reg <= '0;
            fx_reg <= '0;
            buf_reg <= '0;
            cvalid_reg <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mirror_reg <= cfg_data;
            buf_reg <= buf_cur;
            if (in_ready)
                s1_valid_reg <= take;
            if (s1_adv)
                o_valid_reg <= s1_valid_reg;
            if (take)
            begin
                case (command)
                    CMD_READ:
                    begin
                        if (reg_index == REG_STATUS)
                        begin
                            status_reg[7] <= 1'b0;
                            toggle_reg <= 1'b0;
                        end
                        else if (reg_index == REG_DATA)
                            v_reg <= v_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
                    end
                    CMD_WRITE:
                    begin
                        case (reg_index)
                            REG_CTRL:
                            begin
                                ctrl_reg <= write_data;
                                t_reg[11:10] <= write_data[1:0];
                            end
                            REG_MASK:   mask_reg <= write_data;
                            REG_OAMADR: oamp_reg <= write_data;
                            REG_SCROLL:
                            begin
                                if (!toggle_reg)
                                begin
                                    fx_reg <= write_data[2:0];
                                    t_reg[4:0] <= write_data[7:3];
                                end
                                else
                                begin
                                    t_reg[14:12] <= write_data[2:0];
                                    t_reg[9:5] <= write_data[7:3];
                                end
                                toggle_reg <= !toggle_reg;
                            end
                            REG_ADDR:
                            begin
                                if (!toggle_reg)
                                    t_reg[15:8] <= {2'b00, write_data[5:0]};
                                else
                                begin
                                    t_reg[7:0] <= write_data;
                                    v_reg <= {t_reg[15:8], write_data};
                                end
                                toggle_reg <= !toggle_reg;
                            end
                            REG_DATA:
                            begin
                                if (sp == SP_COLOR)
                                begin
                                    color_reg[cidx] <= write_data;
                                    cvalid_reg[cidx] <= 1'b1;
                                end
                                v_reg <= v_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
                            end
                            default: ;
                        endcase
                    end
                    CMD_VBL_ON:  status_reg[7] <= 1'b1;
                    CMD_VBL_OFF: status_reg[7] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            s1_reg <= s0;
        if (s1_adv && s1_valid_reg)
        begin
            o_rd_reg   <= s1_rd;
            o_acc_reg  <= s1_reg.chr_access;
            o_addr_reg <= s1_reg.chr_address;
            o_wd_reg   <= s1_reg.chr_write_data;
        end
    end

    assign out_valid      = o_valid_reg;
    assign read_data      = o_rd_reg;
    assign chr_access     = o_acc_reg;
    assign chr_address    = o_addr_reg;
    assign chr_write_data = o_wd_reg;

    `VCP_ASSERT_NEXT(a_buf_fwd, clk, rst_n, s1_load, buf_reg == $past(s1_val), "buffer lost")
    `VCP_ASSERT_IMPL(a_stall_hold, clk, rst_n, s1_valid_reg && !s1_adv, !in_ready, "stage overrun")
    `VCP_ASSERT_NEXT(a_out_load, clk, rst_n, s1_valid_reg && s1_adv, o_valid_reg, "result dropped")
    `VCP_ASSERT_IMPL(a_one_src, clk, rst_n, s1_valid_reg,
        !(s1_reg.use_oam && s1_reg.use_name), "two memory sources")

endmodule
